FILE: rtl/core/pmm_pkg.sv
// Shared binary32 arithmetic helpers for the packed matrix multiply core.
`default_nettype none
package pmm_pkg;

    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_ZERO = 32'h0000_0000;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    // Any NaN becomes the canonical quiet NaN
    function automatic logic [31:0] fp_canon(input logic [31:0] x);
        if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
            return FP_QNAN;
        end
        return x;
    endfunction

    // Normalize, denormalize and round to nearest even.
    // Value is sig / 2^47 * 2^(e - 127).
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [11:0] e_in,
                                            input logic [47:0] sig_in);
        int                 lz;
        int                 sh;
        logic signed [11:0] e;
        logic [47:0]        sig;
        logic [24:0]        m;
        logic               g;
        logic               st;
        e   = e_in;
        sig = sig_in;
        lz  = 0;
        if (sig == 48'd0) begin
            return {s, 31'd0};
        end
        for (int i = 0; i < 48; i++) begin
            if (sig[i]) lz = 47 - i;
        end
        sig = sig << lz;
        e   = e - 12'(lz);
        // below the normal range: shift right keeping a sticky bit
        if (e < 1) begin
            sh = 1 - int'(e);
            if (sh > 47) begin
                sig = {47'd0, |sig};
            end else begin
                sig = (sig >> sh) | 48'(|(sig & ((48'h1 << sh) - 48'h1)));
            end
            e = 12'sd1;
        end
        m  = {1'b0, sig[47:24]};
        g  = sig[23];
        st = |sig[22:0];
        if (g && (st || m[0])) m = m + 25'd1;
        if (m[24]) begin
            m = m >> 1;
            e = e + 12'sd1;
        end
        if (!m[23]) begin
            return {s, 8'd0, m[22:0]};
        end
        if (e >= 12'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        return {s, e[7:0], m[22:0]};
    endfunction

    // binary32 multiply
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               an, bn, ai, bi, az, bz;
        logic [23:0]        ma, mb;
        logic [7:0]         ea, eb;
        logic [47:0]        p;
        logic signed [11:0] e;
        s  = a[31] ^ b[31];
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        if (an || bn || (ai && bz) || (bi && az)) return FP_QNAN;
        if (ai || bi) return {s, 8'hFF, 23'd0};
        if (az || bz) return {s, 31'd0};
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = ma * mb;
        e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126;
        return fp_pack(s, e, p);
    endfunction

    // binary32 add
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic        an, bn, ai, bi, az, bz;
        logic [23:0] mx, my;
        logic [7:0]  ex, ey, d;
        logic [26:0] xa, ya, yal;
        logic [27:0] sum;
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        az = (a[30:0] == 31'd0);
        bz = (b[30:0] == 31'd0);
        if (an || bn || (ai && bi && (a[31] != b[31]))) return FP_QNAN;
        if (ai) return a;
        if (bi) return b;
        if (az && bz) return {a[31] & b[31], 31'd0};
        if (az) return b;
        if (bz) return a;
        // larger magnitude first
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        mx = {x[30:23] != 8'd0, x[22:0]};
        my = {y[30:23] != 8'd0, y[22:0]};
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        xa = {mx, 3'd0};
        ya = {my, 3'd0};
        if (d >= 8'd27) begin
            yal = 27'(ya != 27'd0);
        end else begin
            yal = (ya >> d) | 27'(|(ya & ((27'h1 << d) - 27'h1)));
        end
        if (x[31] == y[31]) begin
            sum = {1'b0, xa} + {1'b0, yal};
        end else begin
            sum = {1'b0, xa} - {1'b0, yal};
        end
        if (sum == 28'd0) return FP_ZERO;
        return fp_pack(x[31], $signed({4'd0, ex}) + 12'sd1, {sum, 20'd0});
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pmm_dot_pipe.sv
// Three-stage lane product and lane sum pipeline for one packed word pair.
`default_nettype none
module pmm_dot_pipe
    import pmm_pkg::*;
#(
    parameter int LANES = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [32*LANES-1:0]   i_a,
    input  wire logic [32*LANES-1:0]   i_b,
    output logic                       o_valid,
    output logic [31:0]                o_sum
);

    logic        r_v_prod, r_v_part, r_v_sum;
    logic [31:0] r_p0, r_p1, r_s0, r_p1d, r_sum;
    logic [31:0] n_p1;

    // second lane product, +0 when there is only one lane
    generate
        if (LANES > 1) begin : g_two
            assign n_p1 = fp_mul(i_a[63:32], i_b[63:32]);
        end else begin : g_one
            assign n_p1 = FP_ZERO;
        end
    endgenerate

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_prod <= 1'b0;
            r_v_part <= 1'b0;
            r_v_sum  <= 1'b0;
        end else if (i_en) begin
            r_v_prod <= i_valid;
            r_v_part <= r_v_prod;
            r_v_sum  <= r_v_part;
        end
    end

    // products, then 0 + p0, then + p1
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= fp_mul(i_a[31:0], i_b[31:0]);
            r_p1  <= n_p1;
            r_s0  <= fp_add(FP_ZERO, r_p0);
            r_p1d <= r_p1;
            r_sum <= fp_add(r_s0, r_p1d);
        end
    end

    assign o_valid = r_v_sum;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

FILE: rtl/core/packed_fp32_matmul_core.sv
// Top level: input register, lane pipeline, accumulator, counters, output register.
//
//  channel | direction | handshake                 | word
//  in      | in        | i_in_valid / o_in_ready   | i_a_word, i_b_word
//  out     | out       | o_out_valid / i_out_ready | o_c_word, o_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One word pair per cycle while the output word does not stall; a result word is offered
// after its last pair passes the input register, products, first lane add, second lane add,
// and the accumulator add into the output register.
// The accumulator add feeds back into its own register and sets the clock path.
// The whole pipeline stalls together while the output word is not taken.
// Synchronous reset clears valids, counters and the accumulator; no clear pass.
`default_nettype none
module packed_fp32_matmul_core
    import pmm_pkg::*;
#(
    parameter int LANES   = 2,
    parameter int MAX_DIM = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [32*LANES-1:0]  i_a_word,
    input  wire logic [32*LANES-1:0]  i_b_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [32*LANES-1:0]       o_c_word,
    output logic                      o_last,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [12:0]          i_cfg_data
);

    localparam int CW  = $clog2(MAX_DIM + 1);
    localparam int LCW = (LANES > 1) ? $clog2(LANES) : 1;

    logic [12:0]          r_row_count, r_inner_length, r_out_columns;
    logic [CW-1:0]        w_rows, w_pairs, w_groups;
    logic                 w_adv;
    logic                 r_v_in;
    logic [32*LANES-1:0]  r_a, r_b;
    logic                 w_ls_valid;
    logic [31:0]          w_ls;
    logic [31:0]          r_acc, n_acc;
    logic [32*LANES-1:0]  r_partial, n_partial;
    logic [CW-1:0]        r_inner_cnt, r_col_cnt, r_row_cnt;
    logic [LCW-1:0]       r_lane_cnt;
    logic                 w_step, w_inner_end, w_lane_end, w_col_end, w_row_end;
    logic                 r_out_valid, r_last;
    logic [32*LANES-1:0]  r_c_word;

    function automatic logic [CW-1:0] clamp_dim(input logic [12:0] v);
        if (32'(v) > MAX_DIM) return CW'(MAX_DIM);
        if (v == 13'd0) return CW'(1);
        return CW'(v);
    endfunction

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= 13'd1;
            r_inner_length <= 13'd2;
            r_out_columns  <= 13'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS:  r_row_count    <= i_cfg_data;
                REG_INNER: r_inner_length <= i_cfg_data;
                REG_COLS:  r_out_columns  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived limits
    always_comb begin
        w_rows   = clamp_dim(r_row_count);
        w_pairs  = CW'((32'(clamp_dim(r_inner_length)) + LANES - 1) / LANES);
        w_groups = CW'((32'(clamp_dim(r_out_columns)) + LANES - 1) / LANES);
    end

    // global advance: everything moves when the output stage can take a word
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in <= 1'b0;
        end else if (w_adv) begin
            r_v_in <= i_in_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a <= i_a_word;
            r_b <= i_b_word;
        end
    end

    pmm_dot_pipe #(.LANES(LANES)) u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_v_in),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_valid (w_ls_valid),
        .o_sum   (w_ls)
    );

    // accumulate and place finished dot products into lanes
    always_comb begin
        w_step      = w_adv && w_ls_valid;
        n_acc       = fp_add(r_acc, w_ls);
        w_inner_end = !(({1'b0, r_inner_cnt} + 1'b1) < {1'b0, w_pairs});
        w_lane_end  = !((32'(r_lane_cnt) + 1) < LANES);
        w_col_end   = !(({1'b0, r_col_cnt} + 1'b1) < {1'b0, w_groups});
        w_row_end   = !(({1'b0, r_row_cnt} + 1'b1) < {1'b0, w_rows});
        n_partial   = r_partial;
        n_partial[32*r_lane_cnt +: 32] = fp_canon(n_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= FP_ZERO;
            r_partial   <= '0;
            r_inner_cnt <= '0;
            r_lane_cnt  <= '0;
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            if (w_adv) r_out_valid <= 1'b0;
            if (w_step) begin
                if (!w_inner_end) begin
                    r_acc       <= n_acc;
                    r_inner_cnt <= r_inner_cnt + 1'b1;
                end else begin
                    r_acc       <= FP_ZERO;
                    r_inner_cnt <= '0;
                    if (!w_lane_end) begin
                        r_partial  <= n_partial;
                        r_lane_cnt <= r_lane_cnt + 1'b1;
                    end else begin
                        r_partial   <= '0;
                        r_lane_cnt  <= '0;
                        r_out_valid <= 1'b1;
                        r_last      <= w_col_end && w_row_end;
                        if (w_col_end) begin
                            r_col_cnt <= '0;
                            r_row_cnt <= w_row_end ? '0 : r_row_cnt + 1'b1;
                        end else begin
                            r_col_cnt <= r_col_cnt + 1'b1;
                        end
                    end
                end
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (w_step && w_inner_end && w_lane_end) begin
            r_c_word <= n_partial;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_c_word    = r_c_word;
    assign o_last      = r_last;

    // a word appears only after the last lane was filled
    a_emit_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_lane_cnt) == LCW'(LANES - 1))
        else $error("word emitted before all lanes filled");

    // accumulator restarts at +0 after a lane is stored
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_inner_end) |=> r_acc == FP_ZERO)
        else $error("accumulator not cleared after lane store");

    // the final word leaves the position counters at the matrix start
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_row_cnt == '0 && r_col_cnt == '0))
        else $error("counters not restarted after final word");

endmodule
`default_nettype wire

FILE: sim/dot_product_checker.sv
// Checker for the packed matmul core: binary32 dot-product predictor and result compare.
`default_nettype none
module dot_product_checker
    import pmm_pkg::*;
#(
    parameter int LANES   = 2,
    parameter int MAX_DIM = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic [32*LANES-1:0] i_a_word,
    input  wire logic [32*LANES-1:0] i_b_word,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [32*LANES-1:0] i_c_word,
    input  wire logic                i_last,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [12:0]         i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [32*LANES-1:0] c_word;
        logic                last;
    } t_out_word;

    t_out_word           expected_words[$];
    logic [12:0]         rows_reg, inner_reg, cols_reg;
    logic [31:0]         acc;
    logic [32*LANES-1:0] partial;
    int unsigned         inner_cnt, lane_cnt, group_cnt, row_cnt;

    assign o_pending = expected_words.size();

    // Round sig * 2^e to binary32, nearest even, with subnormals
    function automatic logic [31:0] round_f32(input logic s, input logic [63:0] sig,
                                              input int e);
        int          msb, be, sh;
        logic [63:0] m;
        logic        g, st;
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (sig[i]) msb = i;
        end
        be = msb + e + 127;
        if (be < 1) be = 1;
        sh = be - 150 - e;
        g  = 1'b0;
        st = 1'b0;
        if (sh > 64) begin
            m  = 64'd0;
            st = 1'b1;
        end else if (sh > 0) begin
            m  = (sh == 64) ? 64'd0 : (sig >> sh);
            g  = sig[sh-1];
            st = (sig & ((64'h1 << (sh - 1)) - 64'h1)) != 64'd0;
        end else begin
            m = sig << (-sh);
        end
        if (g && (st || m[0])) m = m + 64'd1;
        if (m[24]) begin
            m  = m >> 1;
            be = be + 1;
        end
        if (!m[23]) return {s, 8'd0, m[22:0]};
        if (be >= 255) return {s, 8'hFF, 23'd0};
        return {s, be[7:0], m[22:0]};
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 23'd0;
    endfunction

    function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
        logic s;
        int   ea, eb;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return QNAN;
        if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return QNAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
        return round_f32(s, 64'({a[30:23] != 0, a[22:0]}) * 64'({b[30:23] != 0, b[22:0]}),
                         ea + eb - 300);
    endfunction

    function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic [63:0] xs, ys0, ys, sum;
        int          ex, ey, d;
        if (is_nan(a) || is_nan(b)) return QNAN;
        if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        if (a[30:0] < b[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex  = (x[30:23] == 0) ? 1 : int'(x[30:23]);
        ey  = (y[30:23] == 0) ? 1 : int'(y[30:23]);
        d   = ex - ey;
        // 39 guard bits plus a sticky bit keep the rounding exact
        xs  = 64'({x[30:23] != 0, x[22:0]}) << 39;
        ys0 = 64'({y[30:23] != 0, y[22:0]}) << 39;
        if (d >= 64) ys = 64'(ys0 != 0);
        else         ys = (ys0 >> d) | 64'((ys0 & ((64'h1 << d) - 64'h1)) != 0);
        sum = (x[31] == y[31]) ? xs + ys : xs - ys;
        if (sum == 0) return 32'd0;
        return round_f32(x[31], sum, ex - 189);
    endfunction

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        int unsigned r;
        r = 32'(v);
        if (r > MAX_DIM) r = MAX_DIM;
        if (r == 0) r = 1;
        return r;
    endfunction

    // Advance the predicted core by one word pair
    task automatic predict_pair(input logic [32*LANES-1:0] a, input logic [32*LANES-1:0] b);
        int unsigned pairs, groups, rows;
        logic [31:0] lane_sum, val;
        logic        final_group, final_row;
        pairs  = (clamp_dim(inner_reg) + LANES - 1) / LANES;
        groups = (clamp_dim(cols_reg) + LANES - 1) / LANES;
        rows   = clamp_dim(rows_reg);
        lane_sum = 32'd0;
        for (int p = 0; p < LANES; p++) begin
            lane_sum = add_f32(lane_sum, mul_f32(a[32*p +: 32], b[32*p +: 32]));
        end
        acc = add_f32(acc, lane_sum);
        if (inner_cnt + 1 < pairs) begin
            inner_cnt++;
            return;
        end
        inner_cnt = 0;
        val = is_nan(acc) ? QNAN : acc;
        partial[32*(lane_cnt % LANES) +: 32] = val;
        acc = 32'd0;
        if (lane_cnt + 1 < LANES) begin
            lane_cnt++;
            return;
        end
        lane_cnt    = 0;
        final_group = group_cnt + 1 >= groups;
        final_row   = row_cnt + 1 >= rows;
        expected_words.push_back('{c_word: partial, last: final_group && final_row});
        partial = '0;
        if (final_group) begin
            group_cnt = 0;
            row_cnt   = final_row ? 0 : row_cnt + 1;
        end else begin
            group_cnt++;
        end
    endtask

    // Snoop the three channels
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (!i_rst_n) begin
            rows_reg  <= 13'd1;
            inner_reg <= 13'd2;
            cols_reg  <= 13'd2;
            acc        = 32'd0;
            partial    = '0;
            inner_cnt  = 0;
            lane_cnt   = 0;
            group_cnt  = 0;
            row_cnt    = 0;
            o_fail_count <= 0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROWS:  rows_reg  <= i_cfg_data;
                    REG_INNER: inner_reg <= i_cfg_data;
                    REG_COLS:  cols_reg  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_pair(i_a_word, i_b_word);
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: c_word=%h last=%b", i_c_word, i_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (exp_word.c_word !== i_c_word) begin
                        $error("c_word: expected %h, actual %h", exp_word.c_word, i_c_word);
                        o_fail_count <= o_fail_count + 1;
                    end else if (exp_word.last !== i_last) begin
                        $error("last: expected %b, actual %b", exp_word.last, i_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Stimulus and verdict for the packed matmul core.
`default_nettype none
module testbench
    import pmm_pkg::*;
();

    localparam int          LANES   = 2;
    localparam int          STALL_LIMIT = 5000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [32*LANES-1:0] i_a_word, i_b_word;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [32*LANES-1:0] o_c_word;
    logic                o_last;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [12:0]         i_cfg_data;
    int                  fail_count, pending;
    logic                quiet, hold_req;
    int                  idle_cycles;

    packed_fp32_matmul_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_a_word(i_a_word), .i_b_word(i_b_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_c_word(o_c_word), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    dot_product_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_a_word(i_a_word), .i_b_word(i_b_word),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_c_word(o_c_word), .i_last(o_last),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog: cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("** packed_fp32_matmul_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: random short stalls, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // One binary32 lane: specials, normal-range values, near-overflow values, subnormal or tiny values, raw bits
    function automatic logic [31:0] rand_lane();
        logic [31:0] specials[10];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'h7F7F_FFFF, 32'h0000_0001,
                     32'h0080_0000, 32'h3F80_0000};
        case ($urandom_range(0, 9))
            0:       return specials[$urandom_range(0, 9)];
            1:       return $urandom();
            2:       return {1'($urandom()), 8'($urandom_range(0, 3)), 23'($urandom())};
            3:       return {1'($urandom()), 8'($urandom_range(230, 254)), 23'($urandom())};
            default: return {1'($urandom()), 8'($urandom_range(115, 135)), 23'($urandom())};
        endcase
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [12:0] rows, input logic [12:0] inner,
                             input logic [12:0] cols);
        cfg_write(REG_ROWS, rows);
        cfg_write(REG_INNER, inner);
        cfg_write(REG_COLS, cols);
        @(posedge i_clk);
    endtask

    // Wait for the pipeline to drain: queue empty, then past the latency
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
        i_in_valid <= 1'b1;
        i_a_word   <= a;
        i_b_word   <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    function automatic logic [12:0] rand_dim(input logic allow_big);
        case ($urandom_range(0, 11))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return allow_big ? 13'd8191 : 13'd3;
            3:       return allow_big ? 13'd4096 : 13'd2;
            default: return 13'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        logic [63:0] dir_a[16], dir_b[16];
        int          n;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_a_word    = '0;
        i_b_word    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ROWS;
        i_cfg_data  = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: NaN, inf-inf, inf*0, overflow, underflow, signed zeros
        dir_a = '{64'h7F80_0000_3F80_0000, 64'h0000_0000_7F80_0000,
                  64'h7FC0_0001_3F80_0000, 64'h7F7F_FFFF_7F7F_FFFF,
                  64'h0000_0001_0000_0001, 64'h8000_0000_8000_0000,
                  64'hFF80_0000_7F80_0000, 64'h0080_0000_3F00_0000,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                  64'h3F80_0000_3F80_0001, 64'hBF80_0000_3F80_0000,
                  64'h007F_FFFF_0000_0001, 64'h4B80_0000_3F80_0000,
                  64'h7F80_0000_7F80_0000, 64'hFF7F_FFFF_7F7F_FFFF};
        dir_b = '{64'h3F80_0000_0000_0000, 64'h3F80_0000_BF80_0000,
                  64'h3F80_0000_3F80_0000, 64'h4000_0000_4000_0000,
                  64'h3F00_0000_3F00_0000, 64'h0000_0000_8000_0000,
                  64'h3F80_0000_3F80_0000, 64'h3F00_0000_3F00_0000,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
                  64'h3F80_0000_BF80_0000, 64'h3F80_0000_3F80_0000,
                  64'h3F80_0000_3F00_0000, 64'h3F80_0000_3380_0000,
                  64'hFF80_0000_3F80_0000, 64'h3F80_0000_3F80_0000};
        for (int i = 0; i < 16; i++) send_pair(dir_a[i], dir_b[i]);
        drain();
        configure(13'd1, 13'd1, 13'd0);
        for (int i = 0; i < 8; i++) send_pair(dir_a[i], dir_b[15-i]);
        drain();

        // Random phases over several settings
        for (int ph = 0; ph < 14; ph++) begin
            if (ph == 3) begin
                configure(13'd8191, 13'd8191, 13'd8191);
                n = 200;
            end else if (ph == 5) begin
                configure(13'd2, 13'd2, 13'd4);
                n = 150;
                hold_req = 1'b1;
            end else begin
                configure(rand_dim(1'b1), rand_dim(1'b0), rand_dim(1'b1));
                n = 127;
            end
            if (ph >= 11) quiet = 1'b1;
            for (int i = 0; i < n; i++) send_pair({rand_lane(), rand_lane()},
                                                  {rand_lane(), rand_lane()});
            drain();
        end

        if (fail_count == 0) begin
            $display("** packed_fp32_matmul_core: PASSED **");
        end else begin
            $display("** packed_fp32_matmul_core: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
